// ----- design/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable priority queue core: queue depth,
// count width, status and operation codes, and the entry and cell control
// structs.
// ----------------------------------------------------------------------------
package spq_pkg;

    // queue geometry
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int OCC_W = 5;

    // input item kind
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // result status codes
    typedef enum logic [1:0] {
        ST_INSERTED  = 2'd0,
        ST_REMOVED   = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // operation applied to every cell
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_REMOVE
    } cell_op_t;

    // one stored entry
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } entry_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        cell_op_t op;
        entry_t   new_entry;
    } cell_ctrl_t;

endpackage

// ----- design/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain. On insert it keeps its entry if that entry
// is served no later than the new one, takes the new entry at the boundary,
// and otherwise takes its left neighbor's entry. On remove it takes its right
// neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic       aclk,
    input  cell_ctrl_t ctrl,
    input  logic       cell_valid,
    input  logic       left_stay,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    output entry_t     entry,
    output logic       stay
);

    entry_t entry_reg;
    entry_t entry_next;

    // entry stays in place when new priority is not lower (fifo among equals)
    assign stay = cell_valid && (entry_reg.prio <= ctrl.new_entry.prio);

    // next entry selection
    always_comb begin
        entry_next = entry_reg;
        case (ctrl.op)
            OP_INSERT: begin
                if (stay) begin
                    entry_next = entry_reg;
                end else if (left_stay) begin
                    entry_next = ctrl.new_entry;
                end else begin
                    entry_next = left_entry;
                end
            end
            OP_REMOVE: begin
                entry_next = right_entry;
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    // payload register, no reset
    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ----- design/stable_priority_queue_core.sv -----
// Stable priority queue: a bounded queue of DEPTH entries kept sorted by
// ascending signed priority, equal priorities served first in, first out.
// For each beat the whole row of cells updates in parallel in the
// cycle the beat is accepted (insert shifts the tail right behind the new
// entry, remove shifts everything left), and its result appears in the output
// register on the next cycle. A new beat is taken every cycle while the result
// register is empty or being drained, so sustained throughput is one item per
// cycle; s_ready drops only while a result waits on m_ready.
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Top level: handshake, entry counter, result register and the cell chain.
// ----------------------------------------------------------------------------
module stable_priority_queue_core
    import spq_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // input channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_kind,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic signed [DATA_W-1:0] s_prio,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [1:0]               m_status,
    output logic signed [DATA_W-1:0] m_removed_value,
    output logic [OCC_W-1:0]         m_occupancy
);

    logic                     s_fire;
    logic                     is_full;
    logic                     is_empty;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     m_valid_reg;
    logic                     m_valid_next;
    status_t                  m_status_reg;
    status_t                  m_status_next;
    logic signed [DATA_W-1:0] m_removed_value_reg;
    logic signed [DATA_W-1:0] m_removed_value_next;
    logic [CNT_W+OCC_W-1:0]   count_ext;
    cell_ctrl_t               ctrl;
    entry_t                   cell_q [DEPTH];
    logic [DEPTH-1:0]         cell_stay;
    logic [DEPTH-1:0]         cell_valid;

    // handshake
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_fire   = s_valid && s_ready;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // beat decode, counter and result values
    always_comb begin
        ctrl.op              = OP_HOLD;
        ctrl.new_entry.value = s_value;
        ctrl.new_entry.prio  = s_prio;
        count_next           = count_reg;
        m_valid_next         = m_valid_reg && !m_ready;
        m_status_next        = m_status_reg;
        m_removed_value_next = m_removed_value_reg;
        if (s_fire) begin
            m_valid_next         = 1'b1;
            m_removed_value_next = '0;
            if (s_kind == KIND_INSERT) begin
                if (is_full) begin
                    m_status_next = ST_FULL;
                end else begin
                    ctrl.op       = OP_INSERT;
                    count_next    = count_reg + 1'b1;
                    m_status_next = ST_INSERTED;
                end
            end else begin
                if (is_empty) begin
                    m_status_next = ST_UNDERFLOW;
                end else begin
                    ctrl.op              = OP_REMOVE;
                    count_next           = count_reg - 1'b1;
                    m_status_next        = ST_REMOVED;
                    m_removed_value_next = cell_q[0].value;
                end
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // result payload registers
    always_ff @(posedge aclk) begin
        m_status_reg        <= m_status_next;
        m_removed_value_reg <= m_removed_value_next;
    end

    // cell chain
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign cell_valid[i] = (count_reg > CNT_W'(i));
        if (i == 0 && DEPTH > 1) begin : g_head
            spq_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .cell_valid  (cell_valid[i]),
                .left_stay   (1'b1),
                .left_entry  (ctrl.new_entry),
                .right_entry (cell_q[i+1]),
                .entry       (cell_q[i]),
                .stay        (cell_stay[i])
            );
        end else if (i == DEPTH - 1) begin : g_tail
            spq_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .cell_valid  (cell_valid[i]),
                .left_stay   (cell_stay[i-1]),
                .left_entry  (cell_q[i-1]),
                .right_entry (cell_q[i]),
                .entry       (cell_q[i]),
                .stay        (cell_stay[i])
            );
        end else begin : g_mid
            spq_cell u_cell (
                .aclk        (aclk),
                .ctrl        (ctrl),
                .cell_valid  (cell_valid[i]),
                .left_stay   (cell_stay[i-1]),
                .left_entry  (cell_q[i-1]),
                .right_entry (cell_q[i+1]),
                .entry       (cell_q[i]),
                .stay        (cell_stay[i])
            );
        end
    end

    // outputs
    assign count_ext       = {{OCC_W{1'b0}}, count_reg};
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_removed_value = m_removed_value_reg;
    assign m_occupancy     = count_ext[OCC_W-1:0];

    // counter never passes the depth
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    // a successful remove shrinks the queue by one and reports removed
    a_remove_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && s_kind == KIND_REMOVE && !is_empty |=>
            m_status == ST_REMOVED && count_reg == $past(count_reg) - 1'b1)
        else $error("remove did not update count or status");

    // refused insert leaves a full queue
    a_full_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg == ST_FULL |-> is_full)
        else $error("full status with queue not full");

    // removed value is zero for every other status
    a_removed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != ST_REMOVED |-> m_removed_value_reg == '0)
        else $error("nonzero removed value without remove");

endmodule

// ----- verif/stable_priority_queue_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue_core_tb
// Self-checking bench for the stable priority queue core. A queue of pending
// operations feeds a valid/ready driver. Each accepted beat is run through a
// sorted-list model of the queue, and the monitor compares every result beat
// field by field against the oldest predicted result. Both sides idle at
// random. The receiver also holds off once for a long stretch so that the
// result register stays full and the core stalls its input.
// ----------------------------------------------------------------------------
module stable_priority_queue_core_tb;
    import spq_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 11;
    localparam int LIMIT_CYCLES = 200000;
    localparam int IDLE_PCT     = 9;
    localparam int QUIET_FROM   = 1200;
    localparam int QUIET_TO     = 1700;
    localparam int HOLD_AFTER   = 600;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 8;
    localparam int MAX_REPORTS  = 10;

    // one queue operation on the input channel
    typedef struct {
        logic                     kind;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] prio;
    } queue_op_t;

    // one predicted result beat
    typedef struct {
        status_t                  status;
        logic signed [DATA_W-1:0] removed;
        logic [OCC_W-1:0]         occ;
    } queue_result_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_kind = KIND_INSERT;
    logic signed [DATA_W-1:0] s_value = '0;
    logic signed [DATA_W-1:0] s_prio = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [1:0]               m_status;
    logic signed [DATA_W-1:0] m_removed_value;
    logic [OCC_W-1:0]         m_occupancy;

    queue_op_t     op_backlog[$];
    queue_result_t pending_results[$];

    // sorted copy of the queue contents, head at index 0
    entry_t held[DEPTH];
    int     held_count = 0;

    int cycle = 0;
    int mismatches = 0;
    int beats_out = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;
    bit quiet;

    stable_priority_queue_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_value         (s_value),
        .s_prio          (s_prio),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_removed_value (m_removed_value),
        .m_occupancy     (m_occupancy)
    );

    // clock
    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    assign quiet = (cycle >= QUIET_FROM) && (cycle < QUIET_TO);

    // update the queue copy for one accepted beat and queue its result
    task automatic predict_queue_op(input logic kind, input logic signed [DATA_W-1:0] value,
                                    input logic signed [DATA_W-1:0] prio);
        int            pos;
        queue_result_t r;
        r.removed = '0;
        if (kind == KIND_INSERT) begin
            if (held_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // stable placement: behind every entry of lower or equal priority
                pos = 0;
                while (pos < held_count && $signed(held[pos].prio) <= $signed(prio))
                    pos++;
                for (int i = held_count; i > pos; i--)
                    held[i] = held[i-1];
                held[pos].value = value;
                held[pos].prio  = prio;
                held_count++;
                r.status = ST_INSERTED;
            end
        end else begin
            if (held_count == 0) begin
                r.status = ST_UNDERFLOW;
            end else begin
                r.removed = held[0].value;
                for (int i = 1; i < held_count; i++)
                    held[i-1] = held[i];
                held_count--;
                r.status = ST_REMOVED;
            end
        end
        r.occ = OCC_W'(held_count);
        pending_results.push_back(r);
    endtask

    task automatic add_op(input logic kind, input logic signed [DATA_W-1:0] value,
                          input logic signed [DATA_W-1:0] prio);
        queue_op_t op;
        op.kind  = kind;
        op.value = value;
        op.prio  = prio;
        op_backlog.push_back(op);
    endtask

    // random priority: mostly ties, some full range, some extremes
    function automatic logic signed [DATA_W-1:0] pick_prio();
        int mode;
        mode = $urandom_range(99);
        if (mode < 50)
            return DATA_W'(int'($urandom_range(3)) - 1);
        else if (mode < 80)
            return $urandom;
        else
            case ($urandom_range(3))
                0:       return 32'sh8000_0000;
                1:       return 32'sh7fff_ffff;
                2:       return '0;
                default: return -32'sd1;
            endcase
    endfunction

    // driver: predict on acceptance, then offer the next beat or idle
    always @(posedge aclk) begin : drive
        queue_op_t nxt;
        bit        offer;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predict_queue_op(s_kind, s_value, s_prio);
            if (!s_valid || s_ready) begin
                offer = (op_backlog.size() > 0) && (quiet || $urandom_range(99) >= IDLE_PCT);
                if (offer) begin
                    nxt = op_backlog.pop_front();
                    s_valid <= 1'b1;
                    s_kind  <= nxt.kind;
                    s_value <= nxt.value;
                    s_prio  <= nxt.prio;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check result beats and drive back-pressure
    always @(posedge aclk) begin : watch
        queue_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                beats_out++;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0d] unexpected result beat: status %0d value %0d occ %0d",
                                 cycle, m_status, m_removed_value, m_occupancy);
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status || m_removed_value !== want.removed ||
                        m_occupancy !== want.occ) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("[%0d] mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                     cycle, want.status, want.removed, want.occ,
                                     m_status, m_removed_value, m_occupancy);
                    end
                end
            end
            // one long hold-off so the result register stays full and the core stalls its input
            if (!hold_done && beats_out >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle++;
        if (cycle >= LIMIT_CYCLES) begin
            $display("stable_priority_queue_core verification failed");
            $finish;
        end
    end

    initial begin
        int ins_pct;

        // directed: underflow, priority and value extremes, ties, full refusal
        add_op(KIND_REMOVE, 32'sd0, 32'sd0);
        add_op(KIND_INSERT, 32'sh7fff_ffff, 32'sd0);
        add_op(KIND_INSERT, 32'sh8000_0000, 32'sd0);
        add_op(KIND_INSERT, 32'sd1, 32'sh7fff_ffff);
        add_op(KIND_INSERT, 32'sd2, 32'sh8000_0000);
        add_op(KIND_INSERT, 32'sd3, -32'sd1);
        add_op(KIND_INSERT, 32'sd4, 32'sd1);
        add_op(KIND_INSERT, 32'sd5, 32'sh8000_0000);
        add_op(KIND_INSERT, 32'sd6, 32'sh7fff_ffff);
        add_op(KIND_INSERT, -32'sd1, 32'sd0);
        add_op(KIND_REMOVE, 32'sh7fff_ffff, 32'sh7fff_ffff);
        add_op(KIND_INSERT, 32'sd0, 32'sd5);
        add_op(KIND_INSERT, 32'sd7, 32'sd5);
        add_op(KIND_INSERT, 32'sd8, 32'sd5);
        add_op(KIND_INSERT, 32'sd9, -32'sd5);
        add_op(KIND_INSERT, 32'sd10, -32'sd5);
        add_op(KIND_INSERT, 32'sd11, 32'sd100);
        add_op(KIND_INSERT, 32'sd12, -32'sd100);
        add_op(KIND_INSERT, 32'sd13, 32'sd0);
        add_op(KIND_INSERT, 32'shdead_beef, 32'sd0);
        add_op(KIND_REMOVE, -32'sd1, -32'sd1);
        add_op(KIND_REMOVE, 32'sd0, 32'sd0);
        add_op(KIND_REMOVE, 32'sd0, 32'sd0);

        // random phases, insert-heavy, balanced or remove-heavy to visit full and empty
        for (int ph = 0; ph < 40; ph++) begin
            case ($urandom_range(2))
                0:       ins_pct = 15;
                1:       ins_pct = 50;
                default: ins_pct = 85;
            endcase
            for (int k = 0; k < 50; k++)
                add_op(($urandom_range(99) < ins_pct) ? KIND_INSERT : KIND_REMOVE,
                       $urandom, pick_prio());
        end

        // reset
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // drain stimulus and results, then let the pipeline settle
        while (op_backlog.size() > 0 || s_valid || pending_results.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_results.size() == 0)
            $display("stable_priority_queue_core verification clean");
        else
            $display("stable_priority_queue_core verification failed");
        $finish;
    end

endmodule
